[src/ble_pkg.sv]
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and constants for the bounded list engine: command and status
// codes, sequencer states and the request and result word layouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

  // field widths of the request and result words
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int POS_W         = 7;
  localparam int FIDX_W        = 6;
  localparam int CNT_W         = 7;
  localparam int DEPTH_DEFAULT = 64;

  // command codes; code 7 is unused and rejected as a bad position
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_SEARCH     = 3'd6
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_FULL    = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_SHIFT_UP   = 2'd1,
    ST_SHIFT_DOWN = 2'd2,
    ST_SCAN       = 2'd3
  } state_t;

  // request word
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ble_req_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [FIDX_W-1:0] found_index;
    logic [CNT_W-1:0]  count;
  } ble_rsp_t;

endpackage

`default_nettype wire

[src/bounded_list_engine_core.sv]
// ----------------------------------------------------------------------------
// bounded_list_engine_core
// Ordered list of up to DEPTH signed 32-bit values kept packed in a memory
// with one write and one read port, front at address 0, with push, pop, insert, remove and search.
// ----------------------------------------------------------------------------
// Usage:
//   A request word is taken on the rising edge where start is high and busy
//   is low. Exactly one result word follows, shown on result for one cycle
//   with done high; the receiver cannot hold it off.
//   A rejected command (full, empty, bad position, unused code) gives done
//   in the cycle after it is taken. An insert at index p into a list of n
//   entries moves n-p entries, one per cycle, toward the back, then writes
//   the new value at p, then done. A remove at index p moves the entries
//   after p toward the front, then done. A search reads entries in order
//   from the front and stops at the first hit.
//   One command is handled at a time, bounded by the one read and one
//   write per cycle of the entry memory.
//   busy is high while a command is in flight; a new request may be given
//   in the cycle that done is high.
//   Reset empties the list at once; entry contents are not cleared, since
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_engine_core #(
  parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ble_pkg::ble_req_t request,
  output logic                  busy,
  output logic                  done,
  output ble_pkg::ble_rsp_t     result
);
  import ble_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int IW   = (AW > FIDX_W) ? AW : FIDX_W;

  // entry memory
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  // control and datapath registers
  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              go, go_next;
  logic [AW-1:0]     rptr, rptr_next;
  logic [AW-1:0]     lim, lim_next;
  logic              rd_v, rd_v_next;
  logic [AW-1:0]     rd_a, rd_a_next;
  logic [AW-1:0]     pos_q, pos_q_next;
  logic [DATA_W-1:0] val_q, val_q_next;
  logic              done_next;
  ble_rsp_t          rsp, rsp_next;

  // helpers
  logic [CMPW-1:0]   cnt_w, cnt_m1_w, pos_w, cnt_nw;
  logic [IW-1:0]     fidx_w;
  logic              fin;
  status_t           fin_status;
  logic              fin_found;
  logic [AW-1:0]     p_idx;

  assign cnt_w    = CMPW'(cnt);
  assign cnt_m1_w = cnt_w - CMPW'(1);
  assign pos_w    = CMPW'(request.position);
  assign fidx_w   = IW'(rd_a);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (go) begin
      rdata <= mem[rptr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      go    <= 1'b0;
      rd_v  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      go    <= go_next;
      rd_v  <= rd_v_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rptr  <= rptr_next;
    lim   <= lim_next;
    rd_a  <= rd_a_next;
    pos_q <= pos_q_next;
    val_q <= val_q_next;
    rsp   <= rsp_next;
  end

  // sequencer: next state, memory controls and result
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    go_next    = go;
    rptr_next  = rptr;
    lim_next   = lim;
    rd_v_next  = go;
    rd_a_next  = rptr;
    pos_q_next = pos_q;
    val_q_next = val_q;
    done_next  = 1'b0;
    rsp_next   = rsp;
    mem_we     = 1'b0;
    mem_wa     = rd_a;
    mem_wd     = rdata;
    fin        = 1'b0;
    fin_status = STS_OK;
    fin_found  = 1'b0;
    p_idx      = '0;
    rsp_next.found_index = '0;

    // walk the read pointer toward its limit
    if (go) begin
      if (rptr == lim) begin
        go_next = 1'b0;
      end else if (state == ST_SHIFT_UP) begin
        rptr_next = rptr - AW'(1);
      end else begin
        rptr_next = rptr + AW'(1);
      end
    end

    case (state)
      ST_IDLE: begin
        go_next   = 1'b0;
        rd_v_next = 1'b0;
        if (start) begin
          val_q_next = request.value;
          case (request.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (cnt_w == CMPW'(DEPTH)) begin
                fin        = 1'b1;
                fin_status = STS_FULL;
              end else if (request.command == CMD_INSERT_AT && pos_w > cnt_w) begin
                fin        = 1'b1;
                fin_status = STS_BAD_POS;
              end else begin
                if (request.command == CMD_PUSH_FRONT) begin
                  p_idx = '0;
                end else if (request.command == CMD_PUSH_BACK) begin
                  p_idx = cnt_w[AW-1:0];
                end else begin
                  p_idx = pos_w[AW-1:0];
                end
                pos_q_next = p_idx;
                lim_next   = p_idx;
                rptr_next  = cnt_m1_w[AW-1:0];
                go_next    = (cnt_w != CMPW'(p_idx));
                state_next = ST_SHIFT_UP;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
              if (cnt_w == '0) begin
                fin        = 1'b1;
                fin_status = STS_EMPTY;
              end else if (request.command == CMD_REMOVE_AT && pos_w >= cnt_w) begin
                fin        = 1'b1;
                fin_status = STS_BAD_POS;
              end else begin
                if (request.command == CMD_POP_FRONT) begin
                  p_idx = '0;
                end else if (request.command == CMD_POP_BACK) begin
                  p_idx = cnt_m1_w[AW-1:0];
                end else begin
                  p_idx = pos_w[AW-1:0];
                end
                lim_next   = cnt_m1_w[AW-1:0];
                rptr_next  = p_idx + AW'(1);
                go_next    = (p_idx != cnt_m1_w[AW-1:0]);
                state_next = ST_SHIFT_DOWN;
              end
            end
            CMD_SEARCH: begin
              lim_next   = cnt_m1_w[AW-1:0];
              rptr_next  = '0;
              go_next    = (cnt_w != '0);
              state_next = ST_SCAN;
            end
            default: begin
              fin        = 1'b1;
              fin_status = STS_BAD_POS;
            end
          endcase
        end
      end

      // open a gap: move each word one place toward the back, then drop in
      ST_SHIFT_UP: begin
        mem_we = rd_v || !go;
        if (rd_v) begin
          mem_wa = rd_a + AW'(1);
        end else if (!go) begin
          mem_wa   = pos_q;
          mem_wd   = val_q;
          cnt_next = cnt + CW'(1);
          fin      = 1'b1;
        end
      end

      // close a gap: move each word one place toward the front
      ST_SHIFT_DOWN: begin
        if (rd_v) begin
          mem_we = 1'b1;
          mem_wa = rd_a - AW'(1);
        end else if (!go) begin
          cnt_next = cnt - CW'(1);
          fin      = 1'b1;
        end
      end

      // scan from the front, stop at the first match
      ST_SCAN: begin
        if (rd_v && rdata == val_q) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          go_next   = 1'b0;
          rd_v_next = 1'b0;
          rsp_next.found_index = fidx_w[FIDX_W-1:0];
        end else if (!rd_v && !go) begin
          fin = 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // close out the command and build the result word
    cnt_nw = CMPW'(cnt_next);
    if (fin) begin
      state_next      = ST_IDLE;
      done_next       = 1'b1;
      rsp_next.status = fin_status;
      rsp_next.found  = fin_found;
      rsp_next.count  = cnt_nw[CNT_W-1:0];
    end else begin
      rsp_next = rsp;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign result = rsp;

  // a result word only leaves as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("done raised while a command is still running");

  // the list never holds more than DEPTH entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond DEPTH");

  // no read is in flight while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !go && !rd_v)
    else $error("memory read pending in idle");

  // the memory is only written while shifting
  a_write_shift: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_SHIFT_UP || state == ST_SHIFT_DOWN)
    else $error("memory written outside a shift");

endmodule

`default_nettype wire
